@@ hw/rtl/e2q_pkg.sv @@
// Package: types, constants and arctangent table for the Euler-to-quaternion block.
package e2q_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned FracBits    = 14;
  localparam int unsigned Steps       = (CordicSteps > 24) ? 24 : CordicSteps;

  localparam int unsigned ZW  = 30;
  localparam int unsigned XW  = FracBits + 4;
  localparam int unsigned PW  = 2 * XW;
  localparam int unsigned SW  = XW + 2;

  localparam int unsigned NLanes = 3;

  localparam logic signed [15:0] AngLimit = 16'sd23040;
  localparam logic signed [ZW-1:0] Deg90  = 30'sd94371840;
  localparam logic signed [ZW-1:0] Deg180 = 30'sd188743680;
  localparam logic signed [15:0] OutMax  = 16'sd16384;

  localparam longint GainQ30 = 64'sd652032874;
  localparam longint GainRnd = (FracBits >= 30) ? GainQ30 * (64'sd1 << (FracBits - 30)) :
      ((GainQ30 + (64'sd1 << (29 - FracBits))) >>> (30 - FracBits));
  localparam logic signed [XW-1:0] GainInit = XW'(GainRnd);

  typedef struct packed {
    logic signed [15:0] roll_deg;
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
  } out_word_t;

  typedef struct packed {
    logic signed [XW-1:0] s;
    logic signed [XW-1:0] c;
  } sincos_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
    logic signed [ZW-1:0] r;
    begin
      unique case (i)
        0: r = 30'sd47185920;  1: r = 30'sd27855475;  2: r = 30'sd14718068;
        3: r = 30'sd7471121;   4: r = 30'sd3750058;   5: r = 30'sd1876857;
        6: r = 30'sd938658;    7: r = 30'sd469357;    8: r = 30'sd234682;
        9: r = 30'sd117342;    10: r = 30'sd58671;    11: r = 30'sd29335;
        12: r = 30'sd14668;    13: r = 30'sd7334;     14: r = 30'sd3667;
        15: r = 30'sd1833;     16: r = 30'sd917;      17: r = 30'sd458;
        18: r = 30'sd229;      19: r = 30'sd115;      20: r = 30'sd57;
        21: r = 30'sd29;       22: r = 30'sd14;       23: r = 30'sd7;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // product rounded half up back to FracBits
  function automatic logic signed [XW-1:0] rmul(input logic signed [XW-1:0] a,
                                                input logic signed [XW-1:0] b);
    logic signed [PW-1:0] p;
    begin
      p = PW'(a) * PW'(b) + (PW'(1) <<< (FracBits - 1));
      return XW'(p >>> FracBits);
    end
  endfunction

endpackage

@@ hw/rtl/e2q_cordic_lane.sv @@
// One lane: pipelined CORDIC giving sine and cosine of half an angle.
module e2q_cordic_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic signed [15:0]  ang_i,
  output e2q_pkg::sincos_t    sc_o
);

  localparam int unsigned N = e2q_pkg::Steps;
  localparam int unsigned XW = e2q_pkg::XW;
  localparam int unsigned ZW = e2q_pkg::ZW;

  logic signed [XW-1:0] x_q [N+1];
  logic signed [XW-1:0] y_q [N+1];
  logic signed [ZW-1:0] z_q [N+1];
  logic                 f_q [N+1];

  logic signed [15:0]   a_sat;
  logic signed [ZW-1:0] z0;

  always_comb begin
    if (ang_i > e2q_pkg::AngLimit) begin
      a_sat = e2q_pkg::AngLimit;
    end else if (ang_i < -e2q_pkg::AngLimit) begin
      a_sat = -e2q_pkg::AngLimit;
    end else begin
      a_sat = ang_i;
    end
    z0 = ZW'(a_sat) <<< 13;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z0 > e2q_pkg::Deg90) begin
        z_q[0] <= z0 - e2q_pkg::Deg180;
        f_q[0] <= 1'b1;
      end else if (z0 < -e2q_pkg::Deg90) begin
        z_q[0] <= z0 + e2q_pkg::Deg180;
        f_q[0] <= 1'b1;
      end else begin
        z_q[0] <= z0;
        f_q[0] <= 1'b0;
      end
      x_q[0] <= e2q_pkg::GainInit;
      y_q[0] <= '0;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[g] >= 0) begin
          x_q[g+1] <= x_q[g] - (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] + (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] - e2q_pkg::atan_tab(g);
        end else begin
          x_q[g+1] <= x_q[g] + (y_q[g] >>> g);
          y_q[g+1] <= y_q[g] - (x_q[g] >>> g);
          z_q[g+1] <= z_q[g] + e2q_pkg::atan_tab(g);
        end
        f_q[g+1] <= f_q[g];
      end
    end
  end

  assign sc_o.s = f_q[N] ? -y_q[N] : y_q[N];
  assign sc_o.c = f_q[N] ? -x_q[N] : x_q[N];

  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

@@ hw/rtl/e2q_merge.sv @@
// Merge stage: triple products, sums, rounding and saturation.
module e2q_merge (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  e2q_pkg::sincos_t     e1_i,
  input  e2q_pkg::sincos_t     e2_i,
  input  e2q_pkg::sincos_t     e3_i,
  output e2q_pkg::out_word_t   q_o
);

  localparam int unsigned XW = e2q_pkg::XW;
  localparam int unsigned SW = e2q_pkg::SW;

  logic signed [XW-1:0] cc_q, ss_q, sc_q, cs_q, c3_q, s3_q;
  logic signed [SW-1:0] w_q, i_q, j_q, k_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= e2q_pkg::rmul(e1_i.c, e2_i.c);
      ss_q <= e2q_pkg::rmul(e1_i.s, e2_i.s);
      sc_q <= e2q_pkg::rmul(e1_i.s, e2_i.c);
      cs_q <= e2q_pkg::rmul(e1_i.c, e2_i.s);
      c3_q <= e3_i.c;
      s3_q <= e3_i.s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= SW'(e2q_pkg::rmul(cc_q, c3_q)) + SW'(e2q_pkg::rmul(ss_q, s3_q));
      i_q <= SW'(e2q_pkg::rmul(sc_q, c3_q)) + SW'(e2q_pkg::rmul(cs_q, s3_q));
      j_q <= SW'(e2q_pkg::rmul(cs_q, c3_q)) - SW'(e2q_pkg::rmul(sc_q, s3_q));
      k_q <= SW'(e2q_pkg::rmul(cc_q, s3_q)) - SW'(e2q_pkg::rmul(ss_q, c3_q));
    end
  end

  function automatic logic signed [15:0] to_q14(input logic signed [SW-1:0] v);
    logic signed [SW+15:0] t;
    begin
      if (e2q_pkg::FracBits > 14) begin
        t = ((SW+16)'(v) + ((SW+16)'(1) <<< (e2q_pkg::FracBits - 15)))
            >>> (e2q_pkg::FracBits - 14);
      end else begin
        t = (SW+16)'(v) <<< (14 - e2q_pkg::FracBits);
      end
      if (t > (SW+16)'(e2q_pkg::OutMax)) begin
        return e2q_pkg::OutMax;
      end else if (t < -(SW+16)'(e2q_pkg::OutMax)) begin
        return -e2q_pkg::OutMax;
      end
      return 16'(t);
    end
  endfunction

  assign q_o.quat_w = to_q14(w_q);
  assign q_o.quat_i = to_q14(i_q);
  assign q_o.quat_j = to_q14(j_q);
  assign q_o.quat_k = to_q14(k_q);

endmodule

@@ hw/rtl/euler_to_quaternion.sv @@
// Top level: Euler angles to quaternion, three CORDIC lanes and a merge stage.
//   channel | valid      | stall      | word
//   in      | in_valid_i | in_stall_o | in_word_i  (roll, pitch, yaw)
//   out     | out_valid_o| out_stall_i| out_word_o (w, i, j, k)
// One word per cycle unless out_stall_i holds the pipeline; Steps+4 register
// stages (lane input, CORDIC stages, two product stages, output register). The
// whole pipeline advances when the output register is empty or is taken;
// out_stall_i holds it. Reset clears the valid bits only.
module euler_to_quaternion (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  e2q_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output e2q_pkg::out_word_t   out_word_o
);

  localparam int unsigned D = e2q_pkg::Steps + 4;

  logic              adv;
  logic [D-1:0]      v_q;
  e2q_pkg::sincos_t  sc [e2q_pkg::NLanes];
  e2q_pkg::out_word_t q_w;
  e2q_pkg::out_word_t out_q;

  assign adv        = !(v_q[D-1] && out_stall_i);
  assign in_stall_o = !adv;

  e2q_cordic_lane u_roll  (.clk_i, .rst_ni, .en_i(adv), .ang_i(in_word_i.roll_deg),
                           .sc_o(sc[0]));
  e2q_cordic_lane u_pitch (.clk_i, .rst_ni, .en_i(adv), .ang_i(in_word_i.pitch_deg),
                           .sc_o(sc[1]));
  e2q_cordic_lane u_yaw   (.clk_i, .rst_ni, .en_i(adv), .ang_i(in_word_i.yaw_deg),
                           .sc_o(sc[2]));

  e2q_merge u_merge (.clk_i, .en_i(adv), .e1_i(sc[0]), .e2_i(sc[1]), .e3_i(sc[2]),
                     .q_o(q_w));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[D-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= q_w;
    end
  end

  assign out_valid_o = v_q[D-1];
  assign out_word_o  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> out_word_o.quat_w <= e2q_pkg::OutMax &&
                      out_word_o.quat_w >= -e2q_pkg::OutMax)
    else $error("quat_w out of range");

endmodule

@@ tb/sv/tb.sv @@
// Testbench for euler_to_quaternion: table and random angle words checked against a predictor.
`timescale 1ns / 1ps
module tb;

  localparam int NRand = 750;
  localparam int Lat = e2q_pkg::Steps + 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  e2q_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  e2q_pkg::out_word_t out_word_o;

  euler_to_quaternion uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  e2q_pkg::out_word_t quat_q[$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_out = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint fshr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint rshr(input longint v, input int s);
    if (s <= 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic void half_sincos(input logic signed [15:0] raw,
                                      output longint s, output longint c);
    longint a, z, x, y, t, dx, dy;
    bit flip;
    longint atab[24] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
                         938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334,
                         3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};
    a = raw;
    flip = 1'b0;
    if (a > 23040) a = 23040;
    if (a < -23040) a = -23040;
    z = a * 8192;
    if (z > 94371840) begin
      z -= 188743680;
      flip = 1'b1;
    end else if (z < -94371840) begin
      z += 188743680;
      flip = 1'b1;
    end
    x = rshr(64'sd652032874, 30 - e2q_pkg::FracBits);
    y = 0;
    for (int i = 0; i < e2q_pkg::Steps; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin
        t = x - dx; y = y + dy; z -= atab[i];
      end else begin
        t = x + dx; y = y - dy; z += atab[i];
      end
      x = t;
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endfunction

  function automatic longint prod3(input longint p, input longint q, input longint r);
    return rshr(rshr(p * q, e2q_pkg::FracBits) * r, e2q_pkg::FracBits);
  endfunction

  function automatic logic signed [15:0] to_q14(input longint v);
    v = rshr(v, e2q_pkg::FracBits - 14);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return 16'(v);
  endfunction

  function automatic e2q_pkg::out_word_t rotate_quat(input e2q_pkg::in_word_t w);
    longint s1, c1, s2, c2, s3, c3;
    e2q_pkg::out_word_t q;
    half_sincos(w.roll_deg, s1, c1);
    half_sincos(w.pitch_deg, s2, c2);
    half_sincos(w.yaw_deg, s3, c3);
    q.quat_w = to_q14(prod3(c1, c2, c3) + prod3(s1, s2, s3));
    q.quat_i = to_q14(prod3(s1, c2, c3) + prod3(c1, s2, s3));
    q.quat_j = to_q14(prod3(c1, s2, c3) - prod3(s1, c2, s3));
    q.quat_k = to_q14(prod3(c1, c2, s3) - prod3(s1, s2, c3));
    return q;
  endfunction

  task automatic send(input e2q_pkg::in_word_t w, input bit has_q,
                      input e2q_pkg::out_word_t q);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_word_i <= w;
    in_valid_i <= 1'b1;
    quat_q.push_back(has_q ? q : rotate_quat(w));
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every expected word has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (quat_q.size() == 0);
    @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_ang();
    case ($urandom_range(0, 9))
      0: return 16'($urandom());
      1: return $urandom_range(0, 1) ? 16'sd23040 : -16'sd23040;
      default: return 16'($signed($urandom_range(0, 46080)) - 23040);
    endcase
  endfunction

  // receiver: random stall bursts, one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_out) out_stall_i <= 1'b1;
      else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk_i);
      end else out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quat_q.size() == 0) report("unexpected word", 0, 0);
      else begin
        e2q_pkg::out_word_t e;
        e = quat_q.pop_front();
        if (out_word_o.quat_w !== e.quat_w) report("quat_w", out_word_o.quat_w, e.quat_w);
        if (out_word_o.quat_i !== e.quat_i) report("quat_i", out_word_o.quat_i, e.quat_i);
        if (out_word_o.quat_j !== e.quat_j) report("quat_j", out_word_o.quat_j, e.quat_j);
        if (out_word_o.quat_k !== e.quat_k) report("quat_k", out_word_o.quat_k, e.quat_k);
      end
    end
  end

  typedef struct {
    e2q_pkg::in_word_t w;
    bit has_q;
    e2q_pkg::out_word_t q;
  } row_t;

  row_t dir_tab[] = '{
    '{'{16'sd0, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd23040, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{-16'sd23040, 16'sd0, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd23040, 16'sd0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, -16'sd23040}, 1'b0, '0},
    '{'{16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0, '0},
    '{'{16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, '0},
    '{'{16'sd11520, 16'sd11520, 16'sd11520}, 1'b0, '0},
    '{'{16'sd11521, -16'sd11521, 16'sd11519}, 1'b0, '0},
    '{'{-16'sd11520, 16'sd5760, -16'sd5760}, 1'b0, '0},
    '{'{16'sd5760, 16'sd5760, 16'sd5760}, 1'b0, '0},
    '{'{16'sd1, -16'sd1, 16'sd1}, 1'b0, '0},
    '{'{16'sd17280, -16'sd17280, 16'sd2880}, 1'b0, '0},
    '{'{16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, '0},
    '{'{16'sd23040, 16'sd23040, 16'sd23040}, 1'b0, '0}
  };

  initial begin
    e2q_pkg::in_word_t w;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[n]) send(dir_tab[n].w, dir_tab[n].has_q, dir_tab[n].q);
    for (int n = 0; n < NRand; n++) begin
      if (n == 200) begin
        hold_out = 1'b1;
        fork
          begin
            repeat (60) @(negedge clk_i);
            hold_out = 1'b0;
          end
        join_none
      end
      if (n == 400) drain();
      if (n == 650) no_idle = 1'b1;
      w.roll_deg = rand_ang();
      w.pitch_deg = rand_ang();
      w.yaw_deg = rand_ang();
      send(w, 1'b0, '0);
    end
    drain();
    repeat (Lat + 5) @(posedge clk_i);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
